// ===== rtl/core/adtc_pkg.sv =====
// ----------------------------------------------------------------------------
// adtc_pkg
// Shared types, register map and reset constants of the ADC-to-PCM converter.
// ----------------------------------------------------------------------------
`default_nettype none

package adtc_pkg;

   // configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register reset values
   localparam logic [15:0] RESET_RAW_MAX        = 16'd4095;
   localparam logic [15:0] RESET_GAIN           = 16'd1;
   localparam logic        RESET_TRACK_ENABLE   = 1'b1;
   localparam logic [4:0]  RESET_TRACK_SHIFT    = 5'd10;
   localparam logic [15:0] RESET_DEFAULT_OFFSET = 16'd2048;
   localparam logic        RESET_AUTO_SEED      = 1'b1;
   localparam logic        RESET_FIXED_MODE     = 1'b0;

   // PCM saturation limits
   localparam logic signed [15:0] PCM_MAX = 16'sh7fff;
   localparam logic signed [15:0] PCM_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      REG_RAW_MAX        = 3'd0,
      REG_GAIN           = 3'd1,
      REG_TRACK_ENABLE   = 3'd2,
      REG_TRACK_SHIFT    = 3'd3,
      REG_DEFAULT_OFFSET = 3'd4,
      REG_AUTO_SEED      = 3'd5,
      REG_FIXED_MODE     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_CONVERT    = 2'd0,
      KIND_SET_OFFSET = 2'd1,
      KIND_RESTART    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] raw_max;
      logic [15:0] gain;
      logic        track_enable;
      logic [4:0]  track_shift;
      logic [15:0] default_offset;
      logic        auto_seed;
      logic        fixed_offset_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] raw_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] pcm_value;
      logic               seeded;
   } rsp_payload_type;

   // offset-removed sample handed from the front stage to the scaler
   typedef struct packed {
      logic               valid;
      logic               seeded;
      logic signed [16:0] centered;
   } stage_a_type;

endpackage

`default_nettype wire

// ===== rtl/core/adc_to_pcm_dc_tracking_converter.sv =====
// ----------------------------------------------------------------------------
// adc_to_pcm_dc_tracking_converter
// Path: a conversion passes the input, front and result registers in order.
// Throughput: one request per cycle unless stalled; offset is updated per request.
// Stages: input register, front (clip / offset / tracking), scaler (gain, sat).
// Reset: synchronous; registers to defaults, offset to clipped default offset.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_to_pcm_dc_tracking_converter #(
   parameter int RAW_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire adtc_pkg::req_payload_type           req_payload,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output adtc_pkg::rsp_payload_type                rsp_payload,
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [adtc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [adtc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [adtc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                     csr_pready
);

   adtc_pkg::cfg_type         cfg;
   adtc_pkg::stage_a_type     stage_a;
   adtc_pkg::req_payload_type req_ff;
   logic                      s0_valid_ff;

   // Each stage may load when it is empty or the stage after it moves on,
   // so bubbles collapse; a held result blocks intake only when every stage is full.
   logic b_free;
   logic a_free;
   logic s0_free;
   logic req_take;

   assign b_free    = !rsp_valid || !rsp_stall;
   assign a_free    = !stage_a.valid || b_free;
   assign s0_free   = !s0_valid_ff || a_free;
   assign req_stall = !s0_free;
   assign req_take  = req_valid && s0_free;

   adtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register: request held here until the front stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_free) begin
         s0_valid_ff <= req_valid;
      end
      if (req_take) begin
         req_ff <= req_payload;
      end
   end

   // front: offset state is updated once, as the request leaves the input register
   adtc_front #(
      .RAW_BITS (RAW_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (req_ff),
      .item_valid (s0_valid_ff),
      .load       (a_free),
      .stage_a    (stage_a)
   );

   // scaler: gain and saturation into the result register
   adtc_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .gain        (cfg.gain),
      .stage_a     (stage_a),
      .load        (b_free),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // a request taken into the empty or moving input register is held next cycle
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s0_valid_ff)
      else $error("accepted request lost in input register");

   // a blocked input register keeps its request
   a_s0_hold: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !s0_free |=> s0_valid_ff && $stable(req_ff))
      else $error("blocked input register changed");

   // a blocked front stage keeps its sample
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      stage_a.valid && !b_free |=> stage_a.valid && $stable(stage_a.centered))
      else $error("blocked front stage changed");

   // a seeding sample always gives zero PCM
   a_seed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.seeded |-> rsp_payload.pcm_value == 16'sd0)
      else $error("seeded result is not zero");

endmodule

`default_nettype wire

// ===== rtl/core/adtc_csr.sv =====
// ----------------------------------------------------------------------------
// adtc_csr
// APB-style configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module adtc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [adtc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [adtc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic      [adtc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                     csr_pready,
   output adtc_pkg::cfg_type                        cfg
);

   adtc_pkg::cfg_type       cfg_ff;
   adtc_pkg::cfg_type       cfg_in;
   adtc_pkg::reg_index_type index;
   logic                    wr_en;

   assign index      = adtc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            adtc_pkg::REG_RAW_MAX:        cfg_in.raw_max           = csr_pwdata[15:0];
            adtc_pkg::REG_GAIN:           cfg_in.gain              = csr_pwdata[15:0];
            adtc_pkg::REG_TRACK_ENABLE:   cfg_in.track_enable      = csr_pwdata[0];
            adtc_pkg::REG_TRACK_SHIFT:    cfg_in.track_shift       = csr_pwdata[4:0];
            adtc_pkg::REG_DEFAULT_OFFSET: cfg_in.default_offset    = csr_pwdata[15:0];
            adtc_pkg::REG_AUTO_SEED:      cfg_in.auto_seed         = csr_pwdata[0];
            adtc_pkg::REG_FIXED_MODE:     cfg_in.fixed_offset_mode = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         adtc_pkg::REG_RAW_MAX:        csr_prdata = 32'(cfg_ff.raw_max);
         adtc_pkg::REG_GAIN:           csr_prdata = 32'(cfg_ff.gain);
         adtc_pkg::REG_TRACK_ENABLE:   csr_prdata = 32'(cfg_ff.track_enable);
         adtc_pkg::REG_TRACK_SHIFT:    csr_prdata = 32'(cfg_ff.track_shift);
         adtc_pkg::REG_DEFAULT_OFFSET: csr_prdata = 32'(cfg_ff.default_offset);
         adtc_pkg::REG_AUTO_SEED:      csr_prdata = 32'(cfg_ff.auto_seed);
         adtc_pkg::REG_FIXED_MODE:     csr_prdata = 32'(cfg_ff.fixed_offset_mode);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raw_max           <= adtc_pkg::RESET_RAW_MAX;
         cfg_ff.gain              <= adtc_pkg::RESET_GAIN;
         cfg_ff.track_enable      <= adtc_pkg::RESET_TRACK_ENABLE;
         cfg_ff.track_shift       <= adtc_pkg::RESET_TRACK_SHIFT;
         cfg_ff.default_offset    <= adtc_pkg::RESET_DEFAULT_OFFSET;
         cfg_ff.auto_seed         <= adtc_pkg::RESET_AUTO_SEED;
         cfg_ff.fixed_offset_mode <= adtc_pkg::RESET_FIXED_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/adtc_front.sv =====
// ----------------------------------------------------------------------------
// adtc_front
// Clip, offset removal and DC offset tracking state.
// ----------------------------------------------------------------------------
`default_nettype none

module adtc_front #(
   parameter int RAW_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire adtc_pkg::cfg_type        cfg,
   input  wire adtc_pkg::req_payload_type item,
   input  wire logic                     item_valid,
   input  wire logic                     load,
   output adtc_pkg::stage_a_type         stage_a
);

   localparam int CLIP_BITS = (RAW_BITS < 16) ? RAW_BITS : 16;

   function automatic logic [15:0] clip_raw(input logic [15:0] v, input logic [15:0] lim);
      logic [15:0] m;
      m = 16'(v[CLIP_BITS-1:0]);
      return (m > lim) ? lim : m;
   endfunction

   logic [31:0]        offset_ff;
   logic [31:0]        offset_in;
   logic               ready_ff;
   logic               ready_in;
   adtc_pkg::stage_a_type stage_ff;
   adtc_pkg::stage_a_type stage_in;

   logic [15:0]        raw_c;
   logic [15:0]        dflt_c;
   logic [31:0]        off;
   logic signed [33:0] delta;
   logic signed [33:0] bias;
   logic signed [33:0] step;
   logic signed [16:0] centered;
   logic               is_convert;
   logic               seed;

   assign raw_c  = clip_raw(item.raw_value, cfg.raw_max);
   assign dflt_c = clip_raw(cfg.default_offset, cfg.raw_max);
   assign off    = cfg.fixed_offset_mode ? {dflt_c, 16'h0} : offset_ff;
   assign delta  = $signed({2'b00, raw_c, 16'h0}) - $signed({2'b00, off});

   // truncate toward zero: floor, plus one for a negative value with a fraction
   assign centered = $signed(delta[32:16])
                   + $signed({16'h0, delta[33] && (delta[15:0] != 16'h0)});

   assign bias = delta[33] ? ((34'sd1 <<< cfg.track_shift) - 34'sd1) : 34'sd0;
   assign step = (delta + bias) >>> cfg.track_shift;

   assign is_convert = (adtc_pkg::kind_type'(item.kind) == adtc_pkg::KIND_CONVERT);
   assign seed       = is_convert && !cfg.fixed_offset_mode && !ready_ff;

   always_comb begin
      offset_in = offset_ff;
      ready_in  = ready_ff;
      stage_in  = stage_ff;
      if (load) begin
         stage_in.valid    = item_valid && is_convert;
         stage_in.seeded   = seed;
         stage_in.centered = seed ? 17'sd0 : centered;
      end
      if (load && item_valid) begin
         unique case (adtc_pkg::kind_type'(item.kind))
            adtc_pkg::KIND_SET_OFFSET: begin
               offset_in = {raw_c, 16'h0};
               ready_in  = 1'b1;
            end
            adtc_pkg::KIND_RESTART: begin
               offset_in = {dflt_c, 16'h0};
               ready_in  = !cfg.auto_seed;
            end
            adtc_pkg::KIND_CONVERT: begin
               if (!cfg.fixed_offset_mode) begin
                  if (seed) begin
                     offset_in = {raw_c, 16'h0};
                     ready_in  = 1'b1;
                  end else if (cfg.track_enable) begin
                     offset_in = off + step[31:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff      <= {clip_raw(adtc_pkg::RESET_DEFAULT_OFFSET, adtc_pkg::RESET_RAW_MAX),
                            16'h0};
         ready_ff       <= !adtc_pkg::RESET_AUTO_SEED;
         stage_ff.valid <= 1'b0;
      end else begin
         offset_ff      <= offset_in;
         ready_ff       <= ready_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.seeded   <= stage_in.seeded;
      stage_ff.centered <= stage_in.centered;
   end

   assign stage_a = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/core/adtc_scale.sv =====
// ----------------------------------------------------------------------------
// adtc_scale
// Gain multiply, 16-bit saturation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module adtc_scale (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [15:0]              gain,
   input  wire adtc_pkg::stage_a_type    stage_a,
   input  wire logic                     load,
   output logic                          rsp_valid,
   output adtc_pkg::rsp_payload_type     rsp_payload
);

   logic signed [16:0]        gain_s;
   logic signed [33:0]        product;
   logic signed [15:0]        pcm;
   logic                      valid_ff;
   adtc_pkg::rsp_payload_type payload_ff;

   assign gain_s  = $signed({1'b0, gain});
   assign product = stage_a.centered * gain_s;

   always_comb begin
      if (product > 34'(adtc_pkg::PCM_MAX)) begin
         pcm = adtc_pkg::PCM_MAX;
      end else if (product < 34'(adtc_pkg::PCM_MIN)) begin
         pcm = adtc_pkg::PCM_MIN;
      end else begin
         pcm = product[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= stage_a.valid;
      end
      if (load) begin
         payload_ff.pcm_value <= pcm;
         payload_ff.seeded    <= stage_a.seeded;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

`default_nettype wire

// ===== sim/adc_to_pcm_dc_tracking_converter_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_to_pcm_dc_tracking_converter_tb
// Self-checking bench: drives converter requests and register writes, predicts
// each PCM sample from a shadow of the DC offset state, and checks every
// result in order under random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------

module adc_to_pcm_dc_tracking_converter_tb;

   localparam int         RESULT_LATENCY    = 3;
   localparam int         SETTLE_CYCLES     = RESULT_LATENCY + 5;
   localparam int         STALL_LIMIT       = 4000;
   localparam int         HOLD_OFF_CYCLES   = 300;
   localparam int         HOLD_OFF_REQUESTS = 40;
   localparam int         ITEMS_PER_PROFILE = 650;
   localparam int         ITEMS_PER_SETTING = 130;
   localparam int         MAX_REPORTS       = 10;
   localparam longint     Q16_ONE           = 65536;
   localparam logic [1:0] KIND_UNUSED       = 2'd3;
   localparam logic [2:0] REG_UNMAPPED      = 3'd7;

   // ---------------------------------------------------------------- signals
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   adtc_pkg::req_payload_type           req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   adtc_pkg::rsp_payload_type           rsp_payload;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [adtc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [adtc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [adtc_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   // shadow of the register file and of the offset tracker
   adtc_pkg::cfg_type         cfg_shadow;
   logic [31:0]               offset_q16;
   logic                      offset_valid;
   adtc_pkg::rsp_payload_type pcm_expected[$];

   // traffic shaping
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_req  = 0;
   int hold_left     = 0;

   // bookkeeping
   int idle_cycles     = 0;
   int failures        = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int csr_writes      = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   adc_to_pcm_dc_tracking_converter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------- prediction
   // raw values are 16 bits wide, so only the raw_max clip applies
   function automatic logic [15:0] clip_raw(logic [15:0] v);
      return (v > cfg_shadow.raw_max) ? cfg_shadow.raw_max : v;
   endfunction

   function automatic void restart_offset();
      offset_q16   = {clip_raw(cfg_shadow.default_offset), 16'h0000};
      offset_valid = !cfg_shadow.auto_seed;
   endfunction

   // advance the offset tracker by one accepted request
   function automatic void predict_request(adtc_pkg::req_payload_type r);
      longint                    raw_q16;
      longint                    off;
      longint                    delta;
      longint                    scaled;
      adtc_pkg::rsp_payload_type e;
      case (r.kind)
         adtc_pkg::KIND_SET_OFFSET: begin
            offset_q16   = {clip_raw(r.raw_value), 16'h0000};
            offset_valid = 1'b1;
         end
         adtc_pkg::KIND_RESTART: restart_offset();
         adtc_pkg::KIND_CONVERT: begin
            raw_q16 = longint'(clip_raw(r.raw_value)) * Q16_ONE;
            if (!cfg_shadow.fixed_offset_mode && !offset_valid) begin
               // first sample after restart: becomes the offset, PCM forced to 0
               offset_q16     = raw_q16[31:0];
               offset_valid   = 1'b1;
               e.pcm_value    = '0;
               e.seeded       = 1'b1;
            end else begin
               if (cfg_shadow.fixed_offset_mode)
                  off = longint'(clip_raw(cfg_shadow.default_offset)) * Q16_ONE;
               else
                  off = longint'(offset_q16);
               delta  = raw_q16 - off;
               // signed division truncates toward zero, as the block does
               scaled = (delta / Q16_ONE) * longint'(cfg_shadow.gain);
               if (scaled > adtc_pkg::PCM_MAX) scaled = longint'(adtc_pkg::PCM_MAX);
               if (scaled < adtc_pkg::PCM_MIN) scaled = longint'(adtc_pkg::PCM_MIN);
               if (!cfg_shadow.fixed_offset_mode && cfg_shadow.track_enable)
                  offset_q16 = 32'(off + delta / (longint'(1) << cfg_shadow.track_shift));
               e.pcm_value = scaled[15:0];
               e.seeded    = 1'b0;
            end
            pcm_expected.push_back(e);
         end
         default: ;   // unused kind: no result, no state change
      endcase
   endfunction

   function automatic void report_mismatch(string what, int want, int got);
      if (failures < MAX_REPORTS)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      failures++;
   endfunction

   // ---------------------------------------------------------------- checker
   // outputs sampled at the rising edge, compared in arrival order
   always @(posedge clock) begin
      adtc_pkg::rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (pcm_expected.size() == 0) begin
            report_mismatch("unexpected result (pcm)", 0, int'(rsp_payload.pcm_value));
         end else begin
            want = pcm_expected.pop_front();
            if (rsp_payload.pcm_value !== want.pcm_value)
               report_mismatch("pcm_value", int'(want.pcm_value),
                               int'(rsp_payload.pcm_value));
            if (rsp_payload.seeded !== want.seeded)
               report_mismatch("seeded", int'(want.seeded), int'(rsp_payload.seeded));
         end
      end
   end

   // --------------------------------------------------------------- receiver
   // random stall, or a long hold-off counted here once a test asks for one
   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         hold_left    = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // --------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("[adc_to_pcm_dc_tracking_converter] ERROR");
      $finish;
   end

   // ------------------------------------------------------------ bus drivers
   // All driver tasks start and end on a falling edge. send_request leaves
   // valid high so back-to-back requests never toggle it within one step.
   task automatic send_request(logic [1:0] kind, logic [15:0] value);
      adtc_pkg::req_payload_type r;
      r.kind      = kind;
      r.raw_value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   // stop offering, wait for every pending result, then let the pipe settle
   // since no-result requests may still be in flight
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pcm_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      case (idx)
         adtc_pkg::REG_RAW_MAX:        cfg_shadow.raw_max           = data[15:0];
         adtc_pkg::REG_GAIN:           cfg_shadow.gain              = data[15:0];
         adtc_pkg::REG_TRACK_ENABLE:   cfg_shadow.track_enable      = data[0];
         adtc_pkg::REG_TRACK_SHIFT:    cfg_shadow.track_shift       = data[4:0];
         adtc_pkg::REG_DEFAULT_OFFSET: cfg_shadow.default_offset    = data[15:0];
         adtc_pkg::REG_AUTO_SEED:      cfg_shadow.auto_seed         = data[0];
         adtc_pkg::REG_FIXED_MODE:     cfg_shadow.fixed_offset_mode = data[0];
         default: ;   // unmapped index is dropped
      endcase
      csr_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(adtc_pkg::reg_index_type idx);
      logic [31:0] want;
      logic [31:0] mask;
      logic [31:0] got;
      case (idx)
         adtc_pkg::REG_RAW_MAX: begin
            want = 32'(cfg_shadow.raw_max);           mask = 32'hffff;
         end
         adtc_pkg::REG_GAIN: begin
            want = 32'(cfg_shadow.gain);              mask = 32'hffff;
         end
         adtc_pkg::REG_TRACK_ENABLE: begin
            want = 32'(cfg_shadow.track_enable);      mask = 32'h1;
         end
         adtc_pkg::REG_TRACK_SHIFT: begin
            want = 32'(cfg_shadow.track_shift);       mask = 32'h1f;
         end
         adtc_pkg::REG_DEFAULT_OFFSET: begin
            want = 32'(cfg_shadow.default_offset);    mask = 32'hffff;
         end
         adtc_pkg::REG_AUTO_SEED: begin
            want = 32'(cfg_shadow.auto_seed);         mask = 32'h1;
         end
         default: begin
            want = 32'(cfg_shadow.fixed_offset_mode); mask = 32'h1;
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      got = csr_prdata;
      if ((got & mask) !== want)
         report_mismatch($sformatf("register %s readback", idx.name()), int'(want),
                         int'(got & mask));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // random junk above a register's width half of the time
   function automatic logic [31:0] with_noise(logic [31:0] v, int w);
      return $urandom_range(1) ? (v | ($urandom() << w)) : v;
   endfunction

   task automatic randomize_settings();
      logic [15:0] v;
      case ($urandom_range(3))
         0:       v = 16'hffff;
         1:       v = 16'd4095;
         2:       v = 16'($urandom_range(0, 65535));
         default: v = 16'($urandom_range(0, 300));
      endcase
      csr_write(adtc_pkg::REG_RAW_MAX, with_noise(32'(v), 16));
      case ($urandom_range(3))
         0:       v = 16'($urandom_range(0, 3));
         1:       v = 16'($urandom_range(1, 64));
         2:       v = 16'hffff;
         default: v = 16'($urandom_range(0, 65535));
      endcase
      csr_write(adtc_pkg::REG_GAIN, with_noise(32'(v), 16));
      csr_write(adtc_pkg::REG_TRACK_ENABLE, with_noise(32'($urandom_range(3) != 0), 1));
      case ($urandom_range(3))
         0:       v = 16'd0;
         1:       v = 16'd31;
         default: v = 16'($urandom_range(0, 31));
      endcase
      csr_write(adtc_pkg::REG_TRACK_SHIFT, with_noise(32'(v), 5));
      v = $urandom_range(1) ? 16'($urandom_range(0, 65535)) : (cfg_shadow.raw_max >> 1);
      csr_write(adtc_pkg::REG_DEFAULT_OFFSET, with_noise(32'(v), 16));
      csr_write(adtc_pkg::REG_AUTO_SEED, with_noise($urandom_range(1), 1));
      csr_write(adtc_pkg::REG_FIXED_MODE, with_noise(32'($urandom_range(3) == 0), 1));
      // usually restart so the new default offset and seeding take effect
      if ($urandom_range(3) != 0)
         send_request(adtc_pkg::KIND_RESTART, 16'($urandom_range(0, 65535)));
   endtask

   // mostly conversions, values aimed at the clip point and the live offset
   task automatic send_random_request();
      int          pick;
      logic [15:0] v;
      pick = $urandom_range(99);
      case ($urandom_range(4))
         0, 1:    v = 16'($urandom_range(0, 65535));
         2:       v = cfg_shadow.raw_max + 16'($urandom_range(0, 8)) - 16'd4;
         3:       v = offset_q16[31:16] + 16'($urandom_range(0, 64)) - 16'd32;
         default: v = $urandom_range(1) ? 16'($urandom_range(0, 15))
                                        : 16'hffff - 16'($urandom_range(0, 15));
      endcase
      if (pick < 80)
         send_request(adtc_pkg::KIND_CONVERT, v);
      else if (pick < 90)
         send_request(adtc_pkg::KIND_SET_OFFSET, v);
      else if (pick < 97)
         send_request(adtc_pkg::KIND_RESTART, v);
      else
         send_request(KIND_UNUSED, v);
   endtask

   // ------------------------------------------------------------------ tests
   // reset config: seeding, clip at raw_max, ignored kind, manual offset, restart
   task automatic test_seed_and_kinds();
      send_request(adtc_pkg::KIND_CONVERT, 16'd1000);    // seeds the offset
      send_request(adtc_pkg::KIND_CONVERT, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'hffff);    // clipped to 4095
      send_request(KIND_UNUSED, 16'd1234);
      send_request(adtc_pkg::KIND_SET_OFFSET, 16'd3000);
      send_request(adtc_pkg::KIND_CONVERT, 16'd3000);
      send_request(adtc_pkg::KIND_RESTART, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'd500);     // seeds again
      drain_results();
   endtask

   // full gain drives both PCM rails, no seeding, frozen offset
   task automatic test_gain_saturation();
      csr_write(adtc_pkg::REG_GAIN, 32'hffff);
      csr_write(adtc_pkg::REG_TRACK_ENABLE, 32'd0);
      csr_write(adtc_pkg::REG_AUTO_SEED, 32'd0);
      send_request(adtc_pkg::KIND_RESTART, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'd4095);
      send_request(adtc_pkg::KIND_CONVERT, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'd2048);
      drain_results();
   endtask

   // zero gain, then tracking shift at both ends over the full raw range
   task automatic test_tracking_extremes();
      csr_write(adtc_pkg::REG_GAIN, 32'd0);
      csr_write(adtc_pkg::REG_RAW_MAX, 32'hffff);
      csr_write(adtc_pkg::REG_TRACK_ENABLE, 32'd1);
      csr_write(adtc_pkg::REG_TRACK_SHIFT, 32'd0);
      send_request(adtc_pkg::KIND_SET_OFFSET, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'hffff);    // offset jumps to the sample
      send_request(adtc_pkg::KIND_CONVERT, 16'd0);
      drain_results();
      csr_write(adtc_pkg::REG_GAIN, 32'd1);
      csr_write(adtc_pkg::REG_TRACK_SHIFT, 32'd31);
      send_request(adtc_pkg::KIND_CONVERT, 16'hffff);
      send_request(adtc_pkg::KIND_CONVERT, 16'd1);
      drain_results();
   endtask

   // fixed mode uses the clipped default offset; conversions leave the tracker
   // alone, and an unmapped register write must change nothing
   task automatic test_fixed_mode();
      csr_write(adtc_pkg::REG_RAW_MAX, 32'd1000);
      csr_write(adtc_pkg::REG_DEFAULT_OFFSET, 32'hffff);
      csr_write(adtc_pkg::REG_GAIN, 32'd3);
      csr_write(adtc_pkg::REG_FIXED_MODE, 32'd1);
      csr_write(REG_UNMAPPED, 32'hffff_ffff);
      send_request(adtc_pkg::KIND_CONVERT, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'hffff);
      send_request(adtc_pkg::KIND_SET_OFFSET, 16'd10);
      send_request(adtc_pkg::KIND_RESTART, 16'd0);
      drain_results();
      csr_write(adtc_pkg::REG_FIXED_MODE, 32'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'd500);
      drain_results();
   endtask

   // raw_max of zero clips everything, seeding included
   task automatic test_zero_raw_max();
      csr_write(adtc_pkg::REG_RAW_MAX, 32'd0);
      csr_write(adtc_pkg::REG_AUTO_SEED, 32'd1);
      send_request(adtc_pkg::KIND_RESTART, 16'd0);
      send_request(adtc_pkg::KIND_CONVERT, 16'd12345);
      send_request(adtc_pkg::KIND_CONVERT, 16'hffff);
      drain_results();
   endtask

   task automatic test_register_readback();
      for (int i = adtc_pkg::REG_RAW_MAX; i <= adtc_pkg::REG_FIXED_MODE; i++)
         csr_check(adtc_pkg::reg_index_type'(i));
   endtask

   task automatic test_random_traffic(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int n = 0; n < ITEMS_PER_PROFILE; n++) begin
         if (n % ITEMS_PER_SETTING == 0) begin
            drain_results();
            randomize_settings();
         end
         send_random_request();
      end
      drain_results();
   endtask

   // receiver holds off while requests keep coming: pipe fills, input stalls
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      csr_write(adtc_pkg::REG_FIXED_MODE, 32'd0);
      csr_write(adtc_pkg::REG_RAW_MAX, 32'hffff);
      csr_write(adtc_pkg::REG_GAIN, 32'd2);
      send_request(adtc_pkg::KIND_RESTART, 16'd0);
      rsp_hold_req = HOLD_OFF_CYCLES;
      repeat (HOLD_OFF_REQUESTS)
         send_request(adtc_pkg::KIND_CONVERT, 16'($urandom_range(0, 65535)));
      drain_results();   // sender pauses until every result is back
   endtask

   // ------------------------------------------------------------------- main
   initial begin
      cfg_shadow = '{raw_max:           adtc_pkg::RESET_RAW_MAX,
                     gain:              adtc_pkg::RESET_GAIN,
                     track_enable:      adtc_pkg::RESET_TRACK_ENABLE,
                     track_shift:       adtc_pkg::RESET_TRACK_SHIFT,
                     default_offset:    adtc_pkg::RESET_DEFAULT_OFFSET,
                     auto_seed:         adtc_pkg::RESET_AUTO_SEED,
                     fixed_offset_mode: adtc_pkg::RESET_FIXED_MODE};
      restart_offset();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_seed_and_kinds();
      test_gain_saturation();
      test_tracking_extremes();
      test_fixed_mode();
      test_zero_raw_max();
      test_register_readback();
      test_random_traffic(25, 46);
      test_random_traffic(46, 25);
      test_random_traffic(0, 0);
      test_output_hold_off();
      test_register_readback();
      drain_results();

      $display("run covered %0d requests, %0d checked results, %0d register writes",
               requests_sent, results_checked, csr_writes);
      $display("idle mixes 25/46, 46/25 and none, plus a %0d-cycle output hold-off",
               HOLD_OFF_CYCLES);
      if (failures == 0 && pcm_expected.size() == 0) begin
         $display("[adc_to_pcm_dc_tracking_converter] OK");
      end else begin
         $display("%0d failures, %0d results never arrived", failures, pcm_expected.size());
         $display("[adc_to_pcm_dc_tracking_converter] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
